>>> hdl/ptds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptds_pkg: shared types and constants of the periodic task due scheduler
// sizes of the task lists, entry layout, operation and result codes
// ----------------------------------------------------------------------------
package ptds_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int TIME_BITS   = 32;
    localparam int NUM_LISTS   = 3;

    localparam int HANDLE_W = 32;
    localparam int PERIOD_W = 32;
    localparam int INDEX_W  = 5;

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    // common width for comparing an elapsed time against a period
    localparam int CMP_W  = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CMP_W-1:0]     t_cmp;
    typedef logic [LIST_W-1:0]    t_list;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [INDEX_W-1:0]   t_idx;
    typedef logic [HANDLE_W-1:0]  t_handle;
    typedef logic [PERIOD_W-1:0]  t_period;

    typedef struct packed {
        t_handle handle;
        t_period period;
        t_time   last;
    } t_entry;

    typedef struct packed {
        logic  shift_en;
        t_list sel;
    } t_shift_ctl;

    typedef enum logic {
        OP_REG  = 1'b0,
        OP_EXEC = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_REG  = 2'd0,
        KIND_DUE  = 2'd1,
        KIND_NONE = 2'd2
    } t_kind;

    typedef enum logic {
        STATUS_OK       = 1'b0,
        STATUS_OVERFLOW = 1'b1
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

>>> hdl/ptds_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptds_cell: one position of the entry ring
// holds the entry at this position for every list, shifts the selected one
// ----------------------------------------------------------------------------
module ptds_cell (
    input  wire logic                  i_clk,
    input  wire ptds_pkg::t_shift_ctl  i_shift,
    input  wire ptds_pkg::t_entry      i_ent,
    output ptds_pkg::t_entry           o_ent
);

    ptds_pkg::t_entry r_ent [ptds_pkg::NUM_LISTS];

    always_ff @(posedge i_clk) begin
        if (i_shift.shift_en) begin
            r_ent[i_shift.sel] <= i_ent;
        end
    end

    assign o_ent = r_ent[i_shift.sel];

endmodule
`default_nettype wire

>>> hdl/ptds_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptds_ctrl: sequencer at the head of the entry ring
// checks each entry as it passes, keeps list counts, drives the result word
// ----------------------------------------------------------------------------
module ptds_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_operation,
    input  wire logic [1:0]            i_list_select,
    input  wire logic [31:0]           i_task_handle,
    input  wire logic [31:0]           i_period_us,
    input  wire logic [31:0]           i_now_us,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [1:0]                 o_result_kind,
    output logic                       o_status,
    output logic [31:0]                o_due_handle,
    output logic [4:0]                 o_due_index,
    output logic                       o_last_of_run,
    input  wire ptds_pkg::t_entry      i_head,
    output ptds_pkg::t_entry           o_tail,
    output ptds_pkg::t_shift_ctl       o_shift
);

    ptds_pkg::t_state  r_state, n_state;
    ptds_pkg::t_cnt    r_step, n_step;
    logic              r_found, n_found;
    logic              r_pend_valid, n_pend_valid;
    ptds_pkg::t_handle r_pend_handle, n_pend_handle;
    ptds_pkg::t_idx    r_pend_idx, n_pend_idx;
    ptds_pkg::t_cnt    r_count [ptds_pkg::NUM_LISTS];

    ptds_pkg::t_op     r_op;
    ptds_pkg::t_list   r_sel;
    ptds_pkg::t_handle r_handle;
    ptds_pkg::t_period r_period;
    ptds_pkg::t_time   r_now;
    ptds_pkg::t_status r_status;

    logic              r_out_valid;
    ptds_pkg::t_kind   r_out_kind;
    ptds_pkg::t_status r_out_status;
    ptds_pkg::t_handle r_out_handle;
    ptds_pkg::t_idx    r_out_idx;
    logic              r_out_last;

    logic              w_accept;
    logic              w_sel_ok;
    ptds_pkg::t_list   w_in_list;
    ptds_pkg::t_list   w_cidx;
    ptds_pkg::t_cnt    w_count;
    logic              w_full;
    logic              w_quick;
    logic              w_can_push;
    logic              w_active;
    logic              w_due;
    ptds_pkg::t_time   w_diff;
    logic              w_count_we;
    logic              w_push;
    ptds_pkg::t_kind   w_push_kind;
    ptds_pkg::t_status w_push_status;
    ptds_pkg::t_handle w_push_handle;
    ptds_pkg::t_idx    w_push_idx;
    logic              w_push_last;

    assign o_ready    = (r_state == ptds_pkg::ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_sel_ok   = (int'(i_list_select) < ptds_pkg::NUM_LISTS);
    assign w_in_list  = ptds_pkg::t_list'(i_list_select);
    // one count read port: the incoming list while idle, the working list otherwise
    assign w_cidx     = (r_state == ptds_pkg::ST_IDLE) ? w_in_list : r_sel;
    assign w_count    = r_count[w_cidx];
    assign w_full     = w_sel_ok ? (w_count == ptds_pkg::t_cnt'(ptds_pkg::MAX_ENTRIES)) : 1'b1;
    assign w_quick    = !w_sel_ok || ((i_operation == ptds_pkg::OP_REG) && w_full);
    assign w_can_push = !r_out_valid || i_ready;
    assign w_active   = (r_step < w_count);
    assign w_diff     = r_now - i_head.last;
    assign w_due      = w_active && (i_head.handle != '0)
                        && (ptds_pkg::t_cmp'(w_diff) >= ptds_pkg::t_cmp'(i_head.period));

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        n_found         = r_found;
        n_pend_valid    = r_pend_valid;
        n_pend_handle   = r_pend_handle;
        n_pend_idx      = r_pend_idx;
        o_shift.sel      = r_sel;
        o_shift.shift_en = 1'b0;
        o_tail          = i_head;
        w_count_we      = 1'b0;
        w_push          = 1'b0;
        w_push_kind     = ptds_pkg::KIND_REG;
        w_push_status   = ptds_pkg::STATUS_OK;
        w_push_handle   = '0;
        w_push_idx      = '0;
        w_push_last     = 1'b0;
        case (r_state)
            ptds_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_step       = '0;
                    n_found      = 1'b0;
                    n_pend_valid = 1'b0;
                    n_state      = w_quick ? ptds_pkg::ST_FINISH : ptds_pkg::ST_ROTATE;
                end
            end
            ptds_pkg::ST_ROTATE: begin
                if (r_op == ptds_pkg::OP_EXEC) begin
                    // a second due entry needs room to release the held one
                    if (!(w_due && r_pend_valid && !w_can_push)) begin
                        o_shift.shift_en = 1'b1;
                        if (w_due) begin
                            o_tail.last = r_now;
                            if (r_pend_valid) begin
                                w_push        = 1'b1;
                                w_push_kind   = ptds_pkg::KIND_DUE;
                                w_push_handle = r_pend_handle;
                                w_push_idx    = r_pend_idx;
                            end
                            n_pend_valid  = 1'b1;
                            n_pend_handle = i_head.handle;
                            n_pend_idx    = ptds_pkg::t_idx'(r_step);
                        end
                    end
                end else begin
                    o_shift.shift_en = 1'b1;
                    if (w_active && !r_found && (i_head.handle == r_handle)) begin
                        o_tail.period = r_period;
                        n_found       = 1'b1;
                    end else if ((r_step == w_count) && !r_found) begin
                        o_tail.handle = r_handle;
                        o_tail.period = r_period;
                        o_tail.last   = r_now;
                        n_found       = 1'b1;
                        w_count_we    = 1'b1;
                    end
                end
                if (o_shift.shift_en) begin
                    n_step = r_step + 1'b1;
                    if (r_step == ptds_pkg::t_cnt'(ptds_pkg::MAX_ENTRIES - 1)) begin
                        n_state = ptds_pkg::ST_FINISH;
                    end
                end
            end
            ptds_pkg::ST_FINISH: begin
                if (w_can_push) begin
                    w_push      = 1'b1;
                    w_push_last = 1'b1;
                    if (r_op == ptds_pkg::OP_REG) begin
                        w_push_kind   = ptds_pkg::KIND_REG;
                        w_push_status = r_status;
                    end else if (r_pend_valid) begin
                        w_push_kind   = ptds_pkg::KIND_DUE;
                        w_push_handle = r_pend_handle;
                        w_push_idx    = r_pend_idx;
                    end else begin
                        w_push_kind   = ptds_pkg::KIND_NONE;
                    end
                    n_state = ptds_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptds_pkg::ST_IDLE;
            r_pend_valid <= 1'b0;
            r_found      <= 1'b0;
            r_step       <= '0;
            for (int k = 0; k < ptds_pkg::NUM_LISTS; k++) begin
                r_count[k] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_found      <= n_found;
            r_step       <= n_step;
            if (w_count_we) begin
                r_count[r_sel] <= w_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_handle <= n_pend_handle;
        r_pend_idx    <= n_pend_idx;
        if (w_accept) begin
            r_op     <= ptds_pkg::t_op'(i_operation);
            r_sel    <= w_in_list;
            r_handle <= i_task_handle;
            r_period <= i_period_us;
            r_now    <= ptds_pkg::t_time'(i_now_us);
            r_status <= w_quick ? ptds_pkg::STATUS_OVERFLOW : ptds_pkg::STATUS_OK;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_kind   <= w_push_kind;
            r_out_status <= w_push_status;
            r_out_handle <= w_push_handle;
            r_out_idx    <= w_push_idx;
            r_out_last   <= w_push_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_status      = r_out_status;
    assign o_due_handle  = r_out_handle;
    assign o_due_index   = r_out_idx;
    assign o_last_of_run = r_out_last;

    // the ring moves only while a list is being walked
    a_shift_only_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_shift.shift_en |-> (r_state == ptds_pkg::ST_ROTATE))
        else $error("ring shifted outside a walk");

    // a register walk only runs on a list that still has room
    a_reg_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ptds_pkg::ST_ROTATE) && (r_op == ptds_pkg::OP_REG))
        |-> (w_count < ptds_pkg::t_cnt'(ptds_pkg::MAX_ENTRIES)))
        else $error("register walk on a full list");

    // nothing is held or found before the first entry is looked at
    a_walk_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ptds_pkg::ST_ROTATE) && (r_step == '0)) |-> (!r_pend_valid && !r_found))
        else $error("walk started with stale flags");

    // a pushed word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_push)
        else $error("output word overwritten");

endmodule
`default_nettype wire

>>> hdl/periodic_task_due_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_due_scheduler: periodic task lists with due scan
// keeps several task lists and reports which tasks are due on a scan
// ----------------------------------------------------------------------------
// usage
//  - input channel i_valid / o_ready carries one word: operation, list select,
//    task handle, period and the current time
//  - a register word updates the period of a known handle or appends a new
//    entry; a full list or a bad list select answers overflow at once
//  - an execute word walks the chosen list and returns one word per due task,
//    or a single nothing-due word; the final word of a run has last_of_run set
//  - output channel o_valid / i_ready carries result words from a register
//    stage; the next input word is taken while a result is still waiting
// timing
//  - the entries sit in a ring of cells that rotates one position per cycle
//    past the head sequencer, unless a stalled receiver holds it; every walk
//    passes all MAX_ENTRIES cells and is followed by the closing word
//  - overflow and bad list select skip the walk and go to the closing word
//  - a stalled receiver holds the walk when a second due task needs to go out
// reset
//  - list counts clear at once; entry contents need no clearing
// ----------------------------------------------------------------------------
module periodic_task_due_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_operation,
    input  wire logic [1:0]  i_list_select,
    input  wire logic [31:0] i_task_handle,
    input  wire logic [31:0] i_period_us,
    input  wire logic [31:0] i_now_us,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_result_kind,
    output logic             o_status,
    output logic [31:0]      o_due_handle,
    output logic [4:0]       o_due_index,
    output logic             o_last_of_run
);

    // ring taps: cell 0 feeds the head, the sequencer feeds the last cell
    ptds_pkg::t_entry     w_chain [ptds_pkg::MAX_ENTRIES];
    ptds_pkg::t_entry     w_tail;
    ptds_pkg::t_shift_ctl w_shift;

    ptds_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_list_select (i_list_select),
        .i_task_handle (i_task_handle),
        .i_period_us   (i_period_us),
        .i_now_us      (i_now_us),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_status      (o_status),
        .o_due_handle  (o_due_handle),
        .o_due_index   (o_due_index),
        .o_last_of_run (o_last_of_run),
        .i_head        (w_chain[0]),
        .o_tail        (w_tail),
        .o_shift       (w_shift)
    );

    // each cell takes its upper neighbor's entry on a shift
    for (genvar g = 0; g < ptds_pkg::MAX_ENTRIES; g++) begin : g_cell
        if (g == ptds_pkg::MAX_ENTRIES - 1) begin : g_last
            ptds_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_ent   (w_tail),
                .o_ent   (w_chain[g])
            );
        end else begin : g_mid
            ptds_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_ent   (w_chain[g+1]),
                .o_ent   (w_chain[g])
            );
        end
    end

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the periodic task due scheduler
// drives register and scan words through the valid / ready channels, keeps a
// software copy of the three task lists, and checks every result word in
// order against what that copy predicts, under random stalls on both sides
// ----------------------------------------------------------------------------
module tb;

    // list codes as the list select port sees them
    localparam logic [1:0] LIST_MAIN = 2'd0;
    localparam logic [1:0] LIST_SLOW = 2'd1;
    localparam logic [1:0] LIST_FAST = 2'd2;
    localparam logic [1:0] LIST_BAD  = 2'd3;

    // settling time after a drain, long enough to cover one walk and its closing word
    localparam int SETTLE_CYCLES = 40;
    localparam int POOL_SIZE     = 12;

    typedef struct {
        ptds_pkg::t_kind   kind;
        ptds_pkg::t_status status;
        ptds_pkg::t_handle handle;
        ptds_pkg::t_idx    index;
        logic              last;
    } t_outcome;

    // dut ports, the driven ones at known values from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic        i_operation   = 1'b0;
    logic [1:0]  i_list_select = 2'd0;
    logic [31:0] i_task_handle = '0;
    logic [31:0] i_period_us   = '0;
    logic [31:0] i_now_us      = '0;
    logic        o_valid;
    logic        i_ready       = 1'b1;
    logic [1:0]  o_result_kind;
    logic        o_status;
    logic [31:0] o_due_handle;
    logic [4:0]  o_due_index;
    logic        o_last_of_run;

    // shadow copy of the task lists
    ptds_pkg::t_handle ent_handle [ptds_pkg::NUM_LISTS][ptds_pkg::MAX_ENTRIES];
    ptds_pkg::t_period ent_period [ptds_pkg::NUM_LISTS][ptds_pkg::MAX_ENTRIES];
    ptds_pkg::t_time   ent_last   [ptds_pkg::NUM_LISTS][ptds_pkg::MAX_ENTRIES];
    int                ent_count  [ptds_pkg::NUM_LISTS];

    // result words still owed by the dut, oldest first
    t_outcome outcome_q[$];

    int mismatch_count = 0;
    int stall_left     = 0;
    // calm: no idling on either side
    bit calm           = 1'b0;

    // state of the random traffic
    ptds_pkg::t_handle handle_pool[POOL_SIZE];
    ptds_pkg::t_time   clock_now;

    periodic_task_due_scheduler DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_list_select (i_list_select),
        .i_task_handle (i_task_handle),
        .i_period_us   (i_period_us),
        .i_now_us      (i_now_us),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_status      (o_status),
        .o_due_handle  (o_due_handle),
        .o_due_index   (o_due_index),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // works out the result words of one input word and updates the shadow lists
    function automatic void predict_outcomes(ptds_pkg::t_op op, logic [1:0] sel,
                                             ptds_pkg::t_handle handle,
                                             ptds_pkg::t_period period,
                                             ptds_pkg::t_time now);
        t_outcome        o;
        t_outcome        due[$];
        bit              hit;
        int              cnt;
        ptds_pkg::t_time elapsed;
        o = '{kind: ptds_pkg::KIND_REG, status: ptds_pkg::STATUS_OK, handle: '0,
              index: '0, last: 1'b1};
        if (op == ptds_pkg::OP_REG) begin
            // full list or bad select refuses before any search
            if (sel >= ptds_pkg::NUM_LISTS) begin
                o.status = ptds_pkg::STATUS_OVERFLOW;
            end else if (ent_count[sel] >= ptds_pkg::MAX_ENTRIES) begin
                o.status = ptds_pkg::STATUS_OVERFLOW;
            end else begin
                hit = 1'b0;
                cnt = ent_count[sel];
                for (int i = 0; i < cnt; i++) begin
                    if (!hit && ent_handle[sel][i] == handle) begin
                        ent_period[sel][i] = period;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    ent_handle[sel][cnt] = handle;
                    ent_period[sel][cnt] = period;
                    ent_last[sel][cnt]   = now;
                    ent_count[sel]       = cnt + 1;
                end
            end
            outcome_q.push_back(o);
            return;
        end
        if (sel < ptds_pkg::NUM_LISTS) begin
            for (int i = 0; i < ent_count[sel]; i++) begin
                // handle zero stands for no task and is never due
                if (ent_handle[sel][i] != '0) begin
                    elapsed = now - ent_last[sel][i];
                    if (ent_period[sel][i] == '0 ||
                        ptds_pkg::t_cmp'(elapsed) >= ptds_pkg::t_cmp'(ent_period[sel][i]))
                    begin
                        ent_last[sel][i] = now;
                        due.push_back('{kind: ptds_pkg::KIND_DUE,
                                        status: ptds_pkg::STATUS_OK,
                                        handle: ent_handle[sel][i],
                                        index: ptds_pkg::t_idx'(i),
                                        last: 1'b0});
                    end
                end
            end
        end
        if (due.size() == 0) begin
            o.kind = ptds_pkg::KIND_NONE;
            outcome_q.push_back(o);
        end else begin
            due[due.size()-1].last = 1'b1;
            foreach (due[k]) outcome_q.push_back(due[k]);
        end
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t: mismatch on %s, expected %h, got %h", $time, field, want, got);
        mismatch_count++;
    endtask

    // sends one word; valid stays up after acceptance so back-to-back words
    // never lower and raise it in one step
    task automatic send_word(input ptds_pkg::t_op op, input logic [1:0] sel,
                             input ptds_pkg::t_handle handle,
                             input ptds_pkg::t_period period,
                             input ptds_pkg::t_time now);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        predict_outcomes(op, sel, handle, period, now);
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_list_select <= sel;
        i_task_handle <= handle;
        i_period_us   <= period;
        i_now_us      <= now;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    // holds the sender until every owed word has come back
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one word of mixed traffic on the main and slow lists, with some noise
    task automatic send_random_word();
        int                roll;
        logic [1:0]        sel;
        ptds_pkg::t_period per;
        roll = $urandom_range(0, 9);
        sel  = 2'($urandom_range(0, 1));
        if (roll < 4) begin
            per = ($urandom_range(0, 9) < 7) ? ptds_pkg::t_period'($urandom_range(0, 30))
                                             : ptds_pkg::t_period'($urandom);
            send_word(ptds_pkg::OP_REG, sel, handle_pool[$urandom_range(0, POOL_SIZE-1)],
                      per, clock_now);
        end else if (roll < 9) begin
            // time mostly moves forward in small steps, sometimes jumps anywhere
            if ($urandom_range(0, 9) == 0)
                clock_now = $urandom;
            else
                clock_now = clock_now + ptds_pkg::t_time'($urandom_range(0, 25));
            send_word(ptds_pkg::OP_EXEC, sel, $urandom, $urandom, clock_now);
        end else begin
            // fast list is full by now, the bad select is never valid
            send_word(ptds_pkg::t_op'($urandom_range(0, 1)), 2'($urandom_range(2, 3)),
                      $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_register_basics();
        send_word(ptds_pkg::OP_REG, LIST_MAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(ptds_pkg::OP_REG, LIST_SLOW, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFF0);
        // handle zero registers like any other
        send_word(ptds_pkg::OP_REG, LIST_FAST, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678);
        // update of a known handle
        send_word(ptds_pkg::OP_REG, LIST_MAIN, 32'hFFFF_FFFF, 32'h0000_000A, 32'h0000_0007);
        send_word(ptds_pkg::OP_REG, LIST_FAST, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000);
        // bad list select answers overflow
        send_word(ptds_pkg::OP_REG, LIST_BAD, 32'hA5A5_5A5A, 32'h0000_0001, 32'h0000_0000);
    endtask

    task automatic test_scan_basics();
        send_word(ptds_pkg::OP_EXEC, LIST_MAIN, '0, '0, 32'h0000_0005);
        // elapsed time reaching the period exactly
        send_word(ptds_pkg::OP_EXEC, LIST_MAIN, '0, '0, 32'h0000_000A);
        // period zero across the time wrap
        send_word(ptds_pkg::OP_EXEC, LIST_SLOW, '0, '0, 32'h0000_0005);
        // only handle zero in the list
        send_word(ptds_pkg::OP_EXEC, LIST_FAST, '0, '0, 32'h0000_0100);
        send_word(ptds_pkg::OP_EXEC, LIST_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ptds_pkg::OP_REG, LIST_MAIN, 32'h0000_0002, 32'h0000_0003, 32'h0000_000C);
        send_word(ptds_pkg::OP_EXEC, LIST_MAIN, '0, '0, 32'h0000_000F);
        // largest period: due only one tick short of a full wrap
        send_word(ptds_pkg::OP_REG, LIST_SLOW, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(ptds_pkg::OP_EXEC, LIST_SLOW, '0, '0, 32'hFFFF_FFFE);
        send_word(ptds_pkg::OP_EXEC, LIST_SLOW, '0, '0, 32'hFFFF_FFFF);
        send_word(ptds_pkg::OP_REG, LIST_MAIN, 32'h0000_0002, 32'h0000_0000, 32'h0000_0010);
        send_word(ptds_pkg::OP_EXEC, LIST_MAIN, '0, '0, 32'h0000_0011);
        send_word(ptds_pkg::OP_EXEC, LIST_MAIN, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_001B);
    endtask

    task automatic test_full_list();
        int tag;
        tag = 1;
        while (ent_count[LIST_FAST] < ptds_pkg::MAX_ENTRIES) begin
            send_word(ptds_pkg::OP_REG, LIST_FAST, {24'($urandom), 8'(tag)},
                      ptds_pkg::t_period'($urandom_range(0, 3)), 32'd1000);
            tag++;
        end
        // a full list refuses even an update of a known handle
        send_word(ptds_pkg::OP_REG, LIST_FAST, ent_handle[LIST_FAST][5], 32'd7, 32'd1500);
        send_word(ptds_pkg::OP_REG, LIST_FAST, 32'hDEAD_0000, 32'd7, 32'd1500);
        send_word(ptds_pkg::OP_EXEC, LIST_FAST, '0, '0, 32'd2000);
        send_word(ptds_pkg::OP_EXEC, LIST_FAST, '0, '0, 32'd2001);
        send_word(ptds_pkg::OP_EXEC, LIST_FAST, '0, '0, 32'd2001);
    endtask

    task automatic test_random_traffic();
        clock_now = 32'hFFFF_FF00;
        foreach (handle_pool[k]) begin
            handle_pool[k] = (k == 0) ? ptds_pkg::t_handle'(0)
                                      : ptds_pkg::t_handle'($urandom);
        end
        for (int chunk = 0; chunk < 5; chunk++) begin
            // some chunks run with no idling at all
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 20; n++) send_random_word();
        end
        calm = 1'b0;
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        for (int n = 0; n < 20; n++) send_random_word();
    endtask

    // receiver: ready drops in random bursts unless calm
    always @(posedge i_clk) begin
        if (calm) begin
            stall_left = 0;
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // every accepted result word against the oldest owed one
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (outcome_q.size() == 0) begin
                flag_mismatch("unexpected word", '0, o_due_handle);
            end else begin
                want = outcome_q.pop_front();
                if (o_result_kind !== want.kind)
                    flag_mismatch("result_kind", 32'(want.kind), 32'(o_result_kind));
                if (o_status !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_due_handle !== want.handle)
                    flag_mismatch("due_handle", want.handle, o_due_handle);
                if (o_due_index !== want.index)
                    flag_mismatch("due_index", 32'(want.index), 32'(o_due_index));
                if (o_last_of_run !== want.last)
                    flag_mismatch("last_of_run", 32'(want.last), 32'(o_last_of_run));
            end
        end
    end

    initial begin
        foreach (ent_count[l]) ent_count[l] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_basics();
        test_scan_basics();
        wait_for_drain();
        test_full_list();
        wait_for_drain();
        test_random_traffic();
        test_back_to_back();
        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // safety net well beyond the slowest correct run
    initial begin
        #6_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
